[design/lsr_pkg.sv]
// Shared types, codes and constants for the link supervisor.
package lsr_pkg;

    localparam logic [2:0] CMD_UPDATE = 3'd0;
    localparam logic [2:0] CMD_BEGIN  = 3'd1;
    localparam logic [2:0] CMD_END    = 3'd2;
    localparam logic [2:0] CMD_SET    = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    localparam logic [1:0] ST_DISC = 2'd0;
    localparam logic [1:0] ST_CONN = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NOT_CONN = 2'd1;
    localparam logic [1:0] STS_SEND_ERR = 2'd2;

    localparam logic [1:0] FR_NONE = 2'd0;
    localparam logic [1:0] FR_PUSH = 2'd1;
    localparam logic [1:0] FR_HOLD = 2'd2;
    localparam logic [1:0] FR_REL  = 2'd3;

    localparam logic [2:0] REG_CONNECT_TIMEOUT   = 3'd0;
    localparam logic [2:0] REG_TELEMETRY_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_SPEED_PERIOD      = 3'd2;
    localparam logic [2:0] REG_RETRY_INTERVAL    = 3'd3;
    localparam logic [2:0] REG_RETRY_LIMIT       = 3'd4;

    localparam logic [15:0] RST_CONNECT_TIMEOUT   = 16'd2000;
    localparam logic [15:0] RST_TELEMETRY_TIMEOUT = 16'd1000;
    localparam logic [15:0] RST_SPEED_PERIOD      = 16'd100;
    localparam logic [15:0] RST_RETRY_INTERVAL    = 16'd1000;
    localparam logic [7:0]  RST_RETRY_LIMIT       = 8'd5;

    localparam int ADDR_W     = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic        send_ok;
        logic        telemetry_seen;
        logic [31:0] now_time;
        logic [2:0]  command;
    } t_item;

    typedef struct packed {
        logic [1:0] previous_state;
        logic       state_changed;
        logic [1:0] frame_request;
        logic [1:0] status;
        logic [1:0] link_state;
    } t_result;

    typedef struct packed {
        logic [15:0] connect_timeout;
        logic [15:0] telemetry_timeout;
        logic [15:0] speed_refresh_period;
        logic [15:0] retry_interval;
        logic [7:0]  retry_limit;
    } t_cfg;

    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] stamp,
                                     input logic [15:0] limit);
        logic [31:0] diff;
        diff = now - stamp;
        return diff >= {16'd0, limit};
    endfunction

endpackage

[design/lsr_cfg.sv]
// APB register file holding the supervisor timeouts and retry limit.
module lsr_cfg import lsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.connect_timeout      <= RST_CONNECT_TIMEOUT;
            r_cfg.telemetry_timeout    <= RST_TELEMETRY_TIMEOUT;
            r_cfg.speed_refresh_period <= RST_SPEED_PERIOD;
            r_cfg.retry_interval       <= RST_RETRY_INTERVAL;
            r_cfg.retry_limit          <= RST_RETRY_LIMIT;
        end else if (w_wr) begin
            case (w_idx)
                REG_CONNECT_TIMEOUT:   r_cfg.connect_timeout      <= pwdata[15:0];
                REG_TELEMETRY_TIMEOUT: r_cfg.telemetry_timeout    <= pwdata[15:0];
                REG_SPEED_PERIOD:      r_cfg.speed_refresh_period <= pwdata[15:0];
                REG_RETRY_INTERVAL:    r_cfg.retry_interval       <= pwdata[15:0];
                REG_RETRY_LIMIT:       r_cfg.retry_limit          <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CONNECT_TIMEOUT:   prdata = {16'd0, r_cfg.connect_timeout};
            REG_TELEMETRY_TIMEOUT: prdata = {16'd0, r_cfg.telemetry_timeout};
            REG_SPEED_PERIOD:      prdata = {16'd0, r_cfg.speed_refresh_period};
            REG_RETRY_INTERVAL:    prdata = {16'd0, r_cfg.retry_interval};
            REG_RETRY_LIMIT:       prdata = {24'd0, r_cfg.retry_limit};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

[design/lsr_core.sv]
// Link state, timestamps and the per-transaction next-state logic.
module lsr_core import lsr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [1:0]  r_state;
    logic [31:0] r_conn_start;
    logic        r_conn_known;
    logic [31:0] r_last_tel;
    logic        r_tel_seen;
    logic [31:0] r_last_retry;
    logic [7:0]  r_retry_cnt;
    logic        r_speed_on;
    logic [31:0] r_last_speed;
    logic [31:0] r_last_update;

    logic [1:0]  n_state;
    logic [31:0] n_conn_start;
    logic        n_conn_known;
    logic [31:0] n_last_tel;
    logic        n_tel_seen;
    logic [31:0] n_last_retry;
    logic [7:0]  n_retry_cnt;
    logic        n_speed_on;
    logic [31:0] n_last_speed;
    logic [31:0] n_last_update;

    logic [1:0]  w_status;
    logic [1:0]  w_frame;
    logic [7:0]  w_retry_inc;
    logic [31:0] w_now;

    assign w_now       = i_item.now_time;
    assign w_retry_inc = (r_retry_cnt == 8'hFF) ? r_retry_cnt : r_retry_cnt + 8'd1;

    always_comb begin
        n_state       = r_state;
        n_conn_start  = r_conn_start;
        n_conn_known  = r_conn_known;
        n_last_tel    = r_last_tel;
        n_tel_seen    = r_tel_seen;
        n_last_retry  = r_last_retry;
        n_retry_cnt   = r_retry_cnt;
        n_speed_on    = r_speed_on;
        n_last_speed  = r_last_speed;
        n_last_update = r_last_update;
        w_status      = STS_OK;
        w_frame       = FR_NONE;
        case (i_item.command)
            CMD_UPDATE: begin
                if (r_state != ST_DISC) begin
                    n_last_update = w_now;
                    if (r_state == ST_CONN && !r_conn_known) begin
                        n_conn_start = w_now;
                        n_conn_known = 1'b1;
                    end
                    if (i_item.telemetry_seen) begin
                        n_last_tel = w_now;
                        n_tel_seen = 1'b1;
                        if (r_state == ST_CONN) begin
                            n_state = ST_ACT;
                        end
                    end
                    case (n_state)
                        ST_CONN: begin
                            if (elapsed(w_now, n_conn_start, i_cfg.connect_timeout)) begin
                                n_state      = ST_ERR;
                                n_last_retry = w_now;
                            end
                        end
                        ST_ACT: begin
                            if (n_tel_seen &&
                                elapsed(w_now, n_last_tel, i_cfg.telemetry_timeout)) begin
                                n_state      = ST_ERR;
                                n_last_retry = w_now;
                                n_retry_cnt  = 8'd0;
                            end
                            if (r_speed_on &&
                                elapsed(w_now, r_last_speed, i_cfg.speed_refresh_period)) begin
                                w_frame      = FR_HOLD;
                                n_last_speed = w_now;
                            end
                        end
                        ST_ERR: begin
                            if (elapsed(w_now, r_last_retry, i_cfg.retry_interval)) begin
                                n_retry_cnt = w_retry_inc;
                                if (w_retry_inc > i_cfg.retry_limit) begin
                                    n_state = ST_DISC;
                                end else begin
                                    w_frame = FR_PUSH;
                                    if (i_item.send_ok) begin
                                        n_conn_start = w_now;
                                        n_conn_known = 1'b1;
                                        n_state      = ST_CONN;
                                    end else begin
                                        n_last_retry = w_now;
                                        w_status     = STS_SEND_ERR;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CMD_BEGIN: begin
                n_last_tel    = 32'd0;
                n_tel_seen    = 1'b0;
                n_speed_on    = 1'b0;
                n_last_speed  = 32'd0;
                n_retry_cnt   = 8'd0;
                n_last_update = 32'd0;
                w_frame       = FR_PUSH;
                if (i_item.send_ok) begin
                    n_conn_known = 1'b0;
                    n_state      = ST_CONN;
                end else begin
                    w_status = STS_SEND_ERR;
                end
            end
            CMD_END: begin
                n_speed_on = 1'b0;
                n_state    = ST_DISC;
            end
            CMD_SET: begin
                if (r_state != ST_ACT) begin
                    w_status = STS_NOT_CONN;
                end else begin
                    n_speed_on   = 1'b1;
                    w_frame      = FR_HOLD;
                    n_last_speed = r_last_update;
                end
            end
            CMD_STOP: begin
                if (r_state != ST_ACT) begin
                    w_status = STS_NOT_CONN;
                end else begin
                    n_speed_on = 1'b0;
                    w_frame    = FR_REL;
                    if (!i_item.send_ok) begin
                        w_status = STS_SEND_ERR;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.link_state     = n_state;
    assign o_result.status         = w_status;
    assign o_result.frame_request  = w_frame;
    assign o_result.state_changed  = (n_state != r_state);
    assign o_result.previous_state = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_DISC;
            r_conn_start  <= 32'd0;
            r_conn_known  <= 1'b0;
            r_last_tel    <= 32'd0;
            r_tel_seen    <= 1'b0;
            r_last_retry  <= 32'd0;
            r_retry_cnt   <= 8'd0;
            r_speed_on    <= 1'b0;
            r_last_speed  <= 32'd0;
            r_last_update <= 32'd0;
        end else if (i_step) begin
            r_state       <= n_state;
            r_conn_start  <= n_conn_start;
            r_conn_known  <= n_conn_known;
            r_last_tel    <= n_last_tel;
            r_tel_seen    <= n_tel_seen;
            r_last_retry  <= n_last_retry;
            r_retry_cnt   <= n_retry_cnt;
            r_speed_on    <= n_speed_on;
            r_last_speed  <= n_last_speed;
            r_last_update <= n_last_update;
        end
    end

endmodule

[design/link_supervisor_retry_fsm.sv]
// Top level of the link supervisor: input stage, result stage and register port.
// Link supervisor for a remote device link. Every input transaction (an update tick or
// a begin, end, set-speed or stop-speed command) yields exactly one result transaction
// carrying the new link state, status, requested frame kind and the prior state.
// Transactions are taken one per clock unless the result side stalls: an input
// register feeds a single pass of compare and select logic whose outcome lands in
// the result register, where it is held until the result side takes it.
// While a result waits to be taken the input register can still take one more
// transaction, then the input stalls. Timeouts use modular 32-bit millisecond
// differences against the 16-bit registers; write registers only while idle.
module link_supervisor_retry_fsm import lsr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // command[2:0], now_time[34:3], telemetry_seen[35], send_ok[36], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // link_state[1:0], status[3:2], frame_request[5:4], state_changed[6],
    // previous_state[8:7], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    logic    w_step;
    t_result w_result;
    t_cfg    w_cfg;

    assign w_step        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_step;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

    lsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lsr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[$bits(t_item)-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

endmodule

[sim/tb_link_supervisor_retry_fsm.sv]
// Self-checking testbench for the link supervisor: stream stimulus, APB setup, scoreboard.
module tb_link_supervisor_retry_fsm import lsr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W       = $bits(t_result);
    localparam int CYCLE_LIMIT = 400000;

    class link_scoreboard;
        t_cfg        cfg;
        logic [1:0]  st;
        logic [31:0] conn_start;
        bit          conn_known;
        logic [31:0] tel_stamp;
        bit          tel_ever;
        logic [31:0] retry_stamp;
        logic [7:0]  retry_cnt;
        bit          speed_on;
        logic [31:0] speed_stamp;
        logic [31:0] upd_stamp;
        t_result     outcome_q[$];
        int          mismatches;

        function new();
            cfg.connect_timeout      = RST_CONNECT_TIMEOUT;
            cfg.telemetry_timeout    = RST_TELEMETRY_TIMEOUT;
            cfg.speed_refresh_period = RST_SPEED_PERIOD;
            cfg.retry_interval       = RST_RETRY_INTERVAL;
            cfg.retry_limit          = RST_RETRY_LIMIT;
            st          = ST_DISC;
            conn_start  = '0;
            conn_known  = 0;
            tel_stamp   = '0;
            tel_ever    = 0;
            retry_stamp = '0;
            retry_cnt   = '0;
            speed_on    = 0;
            speed_stamp = '0;
            upd_stamp   = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_CONNECT_TIMEOUT:   cfg.connect_timeout      = val[15:0];
                REG_TELEMETRY_TIMEOUT: cfg.telemetry_timeout    = val[15:0];
                REG_SPEED_PERIOD:      cfg.speed_refresh_period = val[15:0];
                REG_RETRY_INTERVAL:    cfg.retry_interval       = val[15:0];
                REG_RETRY_LIMIT:       cfg.retry_limit          = val[7:0];
                default: ;
            endcase
        endfunction

        function bit timed_out(logic [31:0] now, logic [31:0] stamp, logic [15:0] lim);
            logic [31:0] gap;
            gap = now - stamp;
            return gap >= {16'd0, lim};
        endfunction

        // predicts the outcome of one accepted transaction
        function void note_item(t_item it);
            t_result    res;
            logic [1:0] prev;
            logic [1:0] sts;
            logic [1:0] fr;
            prev = st;
            sts  = STS_OK;
            fr   = FR_NONE;
            case (it.command)
                CMD_UPDATE: begin
                    if (st != ST_DISC) begin
                        upd_stamp = it.now_time;
                        if (st == ST_CONN && !conn_known) begin
                            conn_start = it.now_time;
                            conn_known = 1;
                        end
                        if (it.telemetry_seen) begin
                            tel_stamp = it.now_time;
                            tel_ever  = 1;
                            if (st == ST_CONN) st = ST_ACT;
                        end
                        case (st)
                            ST_CONN: begin
                                if (conn_known &&
                                    timed_out(it.now_time, conn_start, cfg.connect_timeout)) begin
                                    st          = ST_ERR;
                                    retry_stamp = it.now_time;
                                end
                            end
                            ST_ACT: begin
                                if (tel_ever &&
                                    timed_out(it.now_time, tel_stamp, cfg.telemetry_timeout)) begin
                                    st          = ST_ERR;
                                    retry_stamp = it.now_time;
                                    retry_cnt   = '0;
                                end
                                if (speed_on && timed_out(it.now_time, speed_stamp,
                                                          cfg.speed_refresh_period)) begin
                                    fr          = FR_HOLD;
                                    speed_stamp = it.now_time;
                                end
                            end
                            ST_ERR: begin
                                if (timed_out(it.now_time, retry_stamp, cfg.retry_interval)) begin
                                    if (retry_cnt != 8'hFF) retry_cnt = retry_cnt + 8'd1;
                                    if (retry_cnt > cfg.retry_limit) begin
                                        st = ST_DISC;
                                    end else begin
                                        fr = FR_PUSH;
                                        if (it.send_ok) begin
                                            conn_start = it.now_time;
                                            conn_known = 1;
                                            st         = ST_CONN;
                                        end else begin
                                            retry_stamp = it.now_time;
                                            sts         = STS_SEND_ERR;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_BEGIN: begin
                    tel_stamp   = '0;
                    tel_ever    = 0;
                    speed_on    = 0;
                    speed_stamp = '0;
                    retry_cnt   = '0;
                    upd_stamp   = '0;
                    fr          = FR_PUSH;
                    if (it.send_ok) begin
                        conn_known = 0;
                        st         = ST_CONN;
                    end else begin
                        sts = STS_SEND_ERR;
                    end
                end
                CMD_END: begin
                    speed_on = 0;
                    st       = ST_DISC;
                end
                CMD_SET: begin
                    if (st != ST_ACT) begin
                        sts = STS_NOT_CONN;
                    end else begin
                        speed_on    = 1;
                        fr          = FR_HOLD;
                        speed_stamp = upd_stamp;
                    end
                end
                CMD_STOP: begin
                    if (st != ST_ACT) begin
                        sts = STS_NOT_CONN;
                    end else begin
                        speed_on = 0;
                        fr       = FR_REL;
                        if (!it.send_ok) sts = STS_SEND_ERR;
                    end
                end
                default: ;
            endcase
            res.link_state     = st;
            res.status         = sts;
            res.frame_request  = fr;
            res.state_changed  = (st != prev);
            res.previous_state = prev;
            outcome_q.push_back(res);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] raw);
            t_result got;
            t_result want;
            got = t_result'(raw[RES_W-1:0]);
            if (outcome_q.size() == 0) begin
                report($sformatf("result %h with nothing expected", raw));
                return;
            end
            want = outcome_q.pop_front();
            if (got.link_state !== want.link_state)
                report($sformatf("link_state got %0d want %0d", got.link_state, want.link_state));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.frame_request !== want.frame_request)
                report($sformatf("frame_request got %0d want %0d",
                                 got.frame_request, want.frame_request));
            if (got.state_changed !== want.state_changed)
                report($sformatf("state_changed got %0d want %0d",
                                 got.state_changed, want.state_changed));
            if (got.previous_state !== want.previous_state)
                report($sformatf("previous_state got %0d want %0d",
                                 got.previous_state, want.previous_state));
            if (raw[OUT_DATA_W-1:RES_W] !== '0)
                report($sformatf("pad bits not zero: %h", raw));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    link_scoreboard sb;
    bit             calm;
    logic [31:0]    now_ms;
    int             cycles;
    int             stall_left;

    link_supervisor_retry_fsm u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, none in the calm tail
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 15) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(1, 11) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // called at a falling edge, returns at a falling edge
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << 2;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_cfg(t_cfg c);
        apb_write(REG_CONNECT_TIMEOUT,   {16'd0, c.connect_timeout});
        apb_write(REG_TELEMETRY_TIMEOUT, {16'd0, c.telemetry_timeout});
        apb_write(REG_SPEED_PERIOD,      {16'd0, c.speed_refresh_period});
        apb_write(REG_RETRY_INTERVAL,    {16'd0, c.retry_interval});
        apb_write(REG_RETRY_LIMIT,       {24'd0, c.retry_limit});
    endtask

    task automatic send_txn(logic [2:0] cmd, logic [31:0] now, logic tel, logic ok);
        t_item it;
        int    gap;
        if (!calm && $urandom_range(0, 99) < 20) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        it.command        = cmd;
        it.now_time       = now;
        it.telemetry_seen = tel;
        it.send_ok        = ok;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_DATA_W - $bits(t_item)){1'b0}}, it};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid = 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_traffic(int n, int span);
        int          r;
        logic [2:0]  cmd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35)      now_ms = now_ms + $urandom_range(0, 3);
            else if (r < 90) now_ms = now_ms + $urandom_range(0, span);
            else if (r < 97) now_ms = now_ms + $urandom_range(span, 3 * span);
            else             now_ms = $urandom;
            r = $urandom_range(0, 99);
            if (r < 62)      cmd = CMD_UPDATE;
            else if (r < 72) cmd = CMD_BEGIN;
            else if (r < 76) cmd = CMD_END;
            else if (r < 86) cmd = CMD_SET;
            else if (r < 96) cmd = CMD_STOP;
            else             cmd = 3'($urandom_range(5, 7));
            send_txn(cmd, now_ms, $urandom_range(0, 99) < 55, $urandom_range(0, 99) < 80);
        end
    endtask

    t_cfg phase_cfg[6];
    int   phase_span[6];

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 0;
        cycles        = 0;
        sb            = new();

        phase_cfg[0] = '{16'd2000, 16'd1000, 16'd100, 16'd1000, 8'd5};
        phase_cfg[1] = '{16'd30, 16'd25, 16'd7, 16'd12, 8'd2};
        phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254};
        phase_cfg[3] = '{16'd0, 16'd0, 16'd0, 16'd0, 8'd0};
        phase_cfg[4] = '{16'd1, 16'd1, 16'd1, 16'd1, 8'd0};
        phase_cfg[5] = '{16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                         16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                         8'($urandom_range(0, 8))};
        phase_span   = '{2500, 40, 70000, 5, 3, 400};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part
        load_cfg('{16'd50, 16'd40, 16'd10, 16'd20, 8'd1});
        send_txn(CMD_UPDATE, 32'd100, 1'b1, 1'b1);
        send_txn(CMD_SET,    32'd100, 1'b0, 1'b1);
        send_txn(CMD_STOP,   32'd100, 1'b0, 1'b1);
        send_txn(CMD_BEGIN,  32'd100, 1'b0, 1'b0);
        send_txn(CMD_BEGIN,  32'd100, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd100, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd160, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd170, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd180, 1'b0, 1'b0);
        send_txn(CMD_UPDATE, 32'd200, 1'b0, 1'b1);
        send_txn(CMD_BEGIN,  32'd200, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd210, 1'b1, 1'b1);
        send_txn(CMD_SET,    32'd210, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd225, 1'b1, 1'b0);
        send_txn(CMD_STOP,   32'd225, 1'b0, 1'b0);
        send_txn(CMD_SET,    32'd225, 1'b0, 1'b1);
        send_txn(CMD_STOP,   32'd225, 1'b0, 1'b1);
        send_txn(CMD_SET,    32'd225, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd300, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'd320, 1'b0, 1'b1);
        send_txn(3'd5,       32'd320, 1'b1, 1'b1);
        send_txn(3'd6,       32'd320, 1'b0, 1'b0);
        send_txn(3'd7,       32'd320, 1'b1, 1'b0);
        send_txn(CMD_END,    32'd320, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_txn(CMD_BEGIN,  32'hFFFF_FFFF, 1'b0, 1'b1);
        send_txn(CMD_UPDATE, 32'hFFFF_FFF0, 1'b1, 1'b1);
        send_txn(CMD_UPDATE, 32'h0000_0020, 1'b0, 1'b1);

        now_ms = 32'hFFFF_0000;
        for (int p = 0; p < 6; p++) begin
            drain_pipe();
            load_cfg(phase_cfg[p]);
            run_traffic(60, phase_span[p]);
        end

        // counter saturation: limit 255 never gives up
        drain_pipe();
        load_cfg('{16'd0, 16'd5, 16'd3, 16'd0, 8'd255});
        send_txn(CMD_BEGIN, now_ms, 1'b0, 1'b1);
        for (int k = 0; k < 265; k++) begin
            now_ms = now_ms + $urandom_range(0, 2);
            send_txn(CMD_UPDATE, now_ms, 1'($urandom_range(0, 1)), 1'b0);
        end
        send_txn(CMD_UPDATE, now_ms, 1'b0, 1'b1);

        drain_pipe();
        load_cfg(phase_cfg[1]);
        calm = 1;
        run_traffic(60, phase_span[1]);

        s_axis_tvalid = 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
design/lsr_pkg.sv
design/lsr_cfg.sv
design/lsr_core.sv
design/link_supervisor_retry_fsm.sv
sim/tb_link_supervisor_retry_fsm.sv
